// File: hw/rtl/ssd2w_pkg.sv
package ssd2w_pkg;

    localparam int GLYPH_COUNT = 20;
    localparam int DIGIT_COUNT = 4;

    localparam logic [7:0] ADDR_CTRL_WR = 8'h48;
    localparam logic [7:0] ADDR_KEY_RD  = 8'h49;
    localparam logic [7:0] ADDR_DIGIT0  = 8'h68;
    localparam logic [7:0] DP_MASK      = 8'h80;
    localparam logic [7:0] CTRL_ON      = 8'h01;
    localparam logic [7:0] CTRL_SEVEN   = 8'h08;
    localparam logic [7:0] CTRL_OFF     = 8'h00;
    localparam logic [7:0] BLANK_CODE   = 8'h00;

    localparam logic [2:0]  BRIGHTNESS_RESET  = 3'd6;
    localparam logic [15:0] RETRY_LIMIT_RESET = 16'd2000;

    typedef enum logic [2:0] {
        FUNC_TICK  = 3'd0,
        FUNC_DIGIT = 3'd1,
        FUNC_RAW   = 3'd2,
        FUNC_KEY   = 3'd3,
        FUNC_ON    = 3'd4,
        FUNC_OFF   = 3'd5
    } func_t;

    typedef enum logic [1:0] {
        REG_BRIGHTNESS = 2'd0,
        REG_SEVEN_SEG  = 2'd1,
        REG_RETRY      = 2'd2
    } reg_index_t;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'd0,
        PH_S1    = 5'd1,
        PH_S2    = 5'd2,
        PH_S3    = 5'd3,
        PH_WSET  = 5'd4,
        PH_WHI   = 5'd5,
        PH_WLO   = 5'd6,
        PH_AREL  = 5'd7,
        PH_AWAIT = 5'd8,
        PH_ADRV  = 5'd9,
        PH_AHI   = 5'd10,
        PH_ALO   = 5'd11,
        PH_RREL  = 5'd12,
        PH_RHI   = 5'd13,
        PH_RLO   = 5'd14,
        PH_NHI   = 5'd15,
        PH_NLO   = 5'd16,
        PH_P1    = 5'd17,
        PH_P2    = 5'd18,
        PH_P3    = 5'd19
    } phase_t;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       sda_drive;
        logic       busy_res;
        logic       key_valid;
        logic [7:0] key_data;
        logic       ack_timeout;
    } result_t;

    function automatic logic [7:0] glyph_code(input logic [7:0] idx);
        logic [7:0] code;
        case (idx)
            8'd0:    code = 8'h3f;
            8'd1:    code = 8'h06;
            8'd2:    code = 8'h5b;
            8'd3:    code = 8'h4f;
            8'd4:    code = 8'h66;
            8'd5:    code = 8'h6d;
            8'd6:    code = 8'h7d;
            8'd7:    code = 8'h07;
            8'd8:    code = 8'h7f;
            8'd9:    code = 8'h6f;
            8'd10:   code = 8'h77;
            8'd11:   code = 8'h7c;
            8'd12:   code = 8'h39;
            8'd13:   code = 8'h5e;
            8'd14:   code = 8'h79;
            8'd15:   code = 8'h71;
            8'd16:   code = 8'h73;
            8'd17:   code = 8'h40;
            8'd18:   code = 8'h37;
            default: code = BLANK_CODE;
        endcase
        return code;
    endfunction

endpackage

// File: hw/rtl/seven_segment_two_wire_driver.sv
// The result of an accepted tick item is registered in the output stage.
// Throughput: one tick item per cycle while the skid register is empty; the pin
// sequencer advances once per item. The two-entry output stage (result plus skid
// register) keeps input acceptance going for one more item while the output stalls.
// Reset (aresetn low, synchronous) returns the sequencer to idle, empties the
// output stage and restores brightness 6, seven-segment mode 0, retry limit 2000.
module seven_segment_two_wire_driver
    import ssd2w_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_func,
    input  logic [7:0]  s_digit_or_address,
    input  logic [7:0]  s_value,
    input  logic        s_decimal_point,
    input  logic        s_sda_in,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_scl,
    output logic        m_sda_out,
    output logic        m_sda_drive,
    output logic        m_busy_res,
    output logic        m_key_valid,
    output logic [7:0]  m_key_data,
    output logic        m_ack_timeout
);

    logic [2:0]  brightness_reg;
    logic        seven_seg_reg;
    logic [15:0] retry_limit_reg;

    phase_t      phase_reg, phase_next, phase_eff;
    logic [3:0]  bit_count_reg, bit_count_next, bit_count_inc;
    logic [7:0]  shift_reg, shift_next;
    logic [7:0]  address_reg, address_next;
    logic [7:0]  data_reg, data_next;
    logic [15:0] retry_reg, retry_next, retry_inc;
    logic        is_read_reg, is_read_next;
    logic [7:0]  key_reg, key_next;
    logic        data_stage_reg, data_stage_next;
    logic        ack_failed_reg, ack_failed_next;
    logic        sda_level_reg, sda_level_next;

    logic        start;
    logic [7:0]  digit_code;
    logic [7:0]  shift_in;
    logic        scl, drive, busy, key_valid, timeout;

    result_t     out_reg, skid_reg, result;
    logic        out_valid_reg, skid_valid_reg;
    logic        accept;

    assign cfg_ready = 1'b1;
    assign s_ready   = !skid_valid_reg;
    assign accept    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brightness_reg  <= BRIGHTNESS_RESET;
            seven_seg_reg   <= 1'b0;
            retry_limit_reg <= RETRY_LIMIT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_BRIGHTNESS: brightness_reg  <= cfg_data[2:0];
                REG_SEVEN_SEG:  seven_seg_reg   <= cfg_data[0];
                REG_RETRY:      retry_limit_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // A command is taken only by an idle sequencer; it is then launched on this tick.
    always_comb begin
        digit_code = glyph_code(s_value);
        if (s_decimal_point && !seven_seg_reg) begin
            digit_code = digit_code | DP_MASK;
        end
        start        = 1'b0;
        address_next = address_reg;
        data_next    = data_reg;
        is_read_next = is_read_reg;
        if (phase_reg == PH_IDLE) begin
            case (s_func)
                FUNC_DIGIT: begin
                    if (s_digit_or_address < 8'(DIGIT_COUNT)) begin
                        start        = 1'b1;
                        address_next = ADDR_DIGIT0 + {s_digit_or_address[6:0], 1'b0};
                        data_next    = digit_code;
                        is_read_next = 1'b0;
                    end
                end
                FUNC_RAW: begin
                    start        = 1'b1;
                    address_next = s_digit_or_address;
                    data_next    = s_value;
                    is_read_next = 1'b0;
                end
                FUNC_KEY: begin
                    start        = 1'b1;
                    address_next = ADDR_KEY_RD;
                    data_next    = 8'h00;
                    is_read_next = 1'b1;
                end
                FUNC_ON: begin
                    start        = 1'b1;
                    address_next = ADDR_CTRL_WR;
                    data_next    = {1'b0, brightness_reg, 4'b0000}
                                 | (seven_seg_reg ? CTRL_SEVEN : 8'h00) | CTRL_ON;
                    is_read_next = 1'b0;
                end
                FUNC_OFF: begin
                    start        = 1'b1;
                    address_next = ADDR_CTRL_WR;
                    data_next    = CTRL_OFF;
                    is_read_next = 1'b0;
                end
                default: begin
                end
            endcase
        end
        phase_eff = start ? PH_S1 : phase_reg;
    end

    assign bit_count_inc = bit_count_reg + 4'd1;
    assign retry_inc     = retry_reg + 16'd1;
    assign shift_in      = {shift_reg[6:0], s_sda_in};

    // Next state of the sequencer and its datapath.
    always_comb begin
        phase_next      = phase_eff;
        bit_count_next  = bit_count_reg;
        shift_next      = shift_reg;
        retry_next      = retry_reg;
        key_next        = key_reg;
        data_stage_next = data_stage_reg;
        ack_failed_next = ack_failed_reg;
        sda_level_next  = sda_level_reg;
        timeout         = 1'b0;
        key_valid       = 1'b0;
        case (phase_eff)
            PH_IDLE: begin
                sda_level_next = 1'b1;
            end
            PH_S1: begin
                sda_level_next  = 1'b1;
                ack_failed_next = 1'b0;
                phase_next      = PH_S2;
            end
            PH_S2: begin
                sda_level_next = 1'b0;
                phase_next     = PH_S3;
            end
            PH_S3: begin
                sda_level_next  = 1'b0;
                shift_next      = address_next;
                bit_count_next  = 4'd0;
                data_stage_next = 1'b0;
                phase_next      = PH_WSET;
            end
            PH_WSET: begin
                sda_level_next = shift_reg[7];
                phase_next     = PH_WHI;
            end
            PH_WHI: begin
                phase_next = PH_WLO;
            end
            PH_WLO: begin
                shift_next     = {shift_reg[6:0], 1'b0};
                bit_count_next = bit_count_inc;
                if (bit_count_inc >= 4'd8) begin
                    phase_next = data_stage_reg ? PH_NHI : PH_AREL;
                end else begin
                    phase_next = PH_WSET;
                end
            end
            PH_AREL: begin
                sda_level_next = 1'b1;
                retry_next     = 16'd0;
                phase_next     = PH_AWAIT;
            end
            PH_AWAIT: begin
                if (!s_sda_in) begin
                    phase_next = PH_ADRV;
                end else begin
                    retry_next = retry_inc;
                    if (retry_inc >= retry_limit_reg) begin
                        ack_failed_next = 1'b1;
                        timeout         = 1'b1;
                        phase_next      = PH_ADRV;
                    end
                end
            end
            PH_ADRV: begin
                phase_next = PH_AHI;
            end
            PH_AHI: begin
                phase_next = PH_ALO;
            end
            PH_ALO: begin
                bit_count_next = 4'd0;
                if (ack_failed_reg) begin
                    phase_next = PH_S1;
                end else if (is_read_reg) begin
                    shift_next = 8'h00;
                    phase_next = PH_RREL;
                end else begin
                    shift_next      = data_reg;
                    data_stage_next = 1'b1;
                    phase_next      = PH_WSET;
                end
            end
            PH_RREL: begin
                phase_next = PH_RHI;
            end
            PH_RHI: begin
                shift_next     = shift_in;
                bit_count_next = bit_count_inc;
                if (bit_count_inc >= 4'd8) begin
                    key_next  = shift_in;
                    key_valid = 1'b1;
                end
                phase_next = PH_RLO;
            end
            PH_RLO: begin
                phase_next = (bit_count_reg >= 4'd8) ? PH_NHI : PH_RHI;
            end
            PH_NHI: begin
                phase_next = PH_NLO;
            end
            PH_NLO: begin
                phase_next = PH_P1;
            end
            PH_P1: begin
                sda_level_next = 1'b0;
                phase_next     = PH_P2;
            end
            PH_P2: begin
                sda_level_next = 1'b0;
                phase_next     = PH_P3;
            end
            default: begin
                sda_level_next = 1'b1;
                phase_next     = PH_IDLE;
            end
        endcase
    end

    // Pin levels for the tick.
    always_comb begin
        busy  = 1'b1;
        drive = 1'b1;
        scl   = 1'b0;
        case (phase_eff)
            PH_IDLE: begin
                busy = 1'b0;
                scl  = 1'b1;
            end
            PH_S1, PH_S2, PH_WHI, PH_AHI, PH_NHI, PH_P2, PH_P3: begin
                scl = 1'b1;
            end
            PH_AREL, PH_AWAIT, PH_RREL, PH_RLO: begin
                drive = 1'b0;
            end
            PH_RHI: begin
                drive = 1'b0;
                scl   = 1'b1;
            end
            default: begin
                scl = 1'b0;
            end
        endcase
    end

    always_comb begin
        result.scl         = scl;
        result.sda_out     = sda_level_next;
        result.sda_drive   = drive;
        result.busy_res    = busy;
        result.key_valid   = key_valid;
        result.key_data    = key_next;
        result.ack_timeout = timeout;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            bit_count_reg  <= 4'd0;
            shift_reg      <= 8'h00;
            address_reg    <= 8'h00;
            data_reg       <= 8'h00;
            retry_reg      <= 16'd0;
            is_read_reg    <= 1'b0;
            key_reg        <= 8'h00;
            data_stage_reg <= 1'b0;
            ack_failed_reg <= 1'b0;
            sda_level_reg  <= 1'b1;
        end else if (accept) begin
            phase_reg      <= phase_next;
            bit_count_reg  <= bit_count_next;
            shift_reg      <= shift_next;
            address_reg    <= address_next;
            data_reg       <= data_next;
            retry_reg      <= retry_next;
            is_read_reg    <= is_read_next;
            key_reg        <= key_next;
            data_stage_reg <= data_stage_next;
            ack_failed_reg <= ack_failed_next;
            sda_level_reg  <= sda_level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= accept;
            end
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (accept) begin
                out_reg <= result;
            end
        end else if (accept) begin
            skid_reg <= result;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_scl         = out_reg.scl;
    assign m_sda_out     = out_reg.sda_out;
    assign m_sda_drive   = out_reg.sda_drive;
    assign m_busy_res    = out_reg.busy_res;
    assign m_key_valid   = out_reg.key_valid;
    assign m_key_data    = out_reg.key_data;
    assign m_ack_timeout = out_reg.ack_timeout;

endmodule

// File: hw/rtl/ssd2w_checker.sv
module ssd2w_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_scl,
    input logic       m_sda_out,
    input logic       m_sda_drive,
    input logic       m_busy_res,
    input logic       m_key_valid,
    input logic       m_ack_timeout
);

    // An idle bus is held with both lines high and driven.
    a_idle_lines: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_busy_res) |-> (m_scl && m_sda_out && m_sda_drive))
        else $error("idle item does not hold both lines high");

    // A key bit is sampled with the clock high and the data line released.
    a_key_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_key_valid) |-> (m_scl && !m_sda_drive && m_busy_res))
        else $error("key byte completed outside a released clock-high tick");

    // The acknowledge wait expires with the clock low and the data line released.
    a_ack_timeout: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ack_timeout) |-> (!m_scl && !m_sda_drive && m_busy_res))
        else $error("acknowledge timeout outside the acknowledge wait");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_scl) && $stable(m_sda_out)))
        else $error("stalled result item changed");

endmodule

bind seven_segment_two_wire_driver ssd2w_checker u_ssd2w_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_scl         (m_scl),
    .m_sda_out     (m_sda_out),
    .m_sda_drive   (m_sda_drive),
    .m_busy_res    (m_busy_res),
    .m_key_valid   (m_key_valid),
    .m_ack_timeout (m_ack_timeout)
);

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import ssd2w_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] sel;
        logic [7:0] val;
        logic       dp;
        logic       sda;
    } bus_tick_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_func = '0;
    logic [7:0]  s_digit_or_address = '0;
    logic [7:0]  s_value = '0;
    logic        s_decimal_point = 1'b0;
    logic        s_sda_in = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_scl;
    logic        m_sda_out;
    logic        m_sda_drive;
    logic        m_busy_res;
    logic        m_key_valid;
    logic [7:0]  m_key_data;
    logic        m_ack_timeout;

    seven_segment_two_wire_driver dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_func             (s_func),
        .s_digit_or_address (s_digit_or_address),
        .s_value            (s_value),
        .s_decimal_point    (s_decimal_point),
        .s_sda_in           (s_sda_in),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_scl              (m_scl),
        .m_sda_out          (m_sda_out),
        .m_sda_drive        (m_sda_drive),
        .m_busy_res         (m_busy_res),
        .m_key_valid        (m_key_valid),
        .m_key_data         (m_key_data),
        .m_ack_timeout      (m_ack_timeout)
    );

    logic [7:0] segment_rom [0:GLYPH_COUNT-1] = '{
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f,
        8'h77, 8'h7c, 8'h39, 8'h5e, 8'h79, 8'h71, 8'h73, 8'h40, 8'h37, 8'h00
    };

    // Register copies and sequencer state of the pin predictor.
    logic [2:0]  brightness = BRIGHTNESS_RESET;
    logic        seg7_mode = 1'b0;
    logic [15:0] retry_limit = RETRY_LIMIT_RESET;
    phase_t      bus_phase = PH_IDLE;
    logic [3:0]  shift_count = '0;
    logic [7:0]  shifter = '0;
    logic [7:0]  addr_q = '0;
    logic [7:0]  data_q = '0;
    logic [15:0] retries = '0;
    logic        reading = 1'b0;
    logic [7:0]  key_q = '0;
    logic        in_data = 1'b0;
    logic        nacked = 1'b0;
    logic        sda_level = 1'b1;

    bus_tick_t tick_backlog[$];
    result_t   pin_states_due[$];

    int  queued_total = 0;
    int  items_accepted = 0;
    int  results_checked = 0;
    int  mismatches = 0;
    int  cycle_count = 0;
    int  transactions = 0;
    int  timeouts_seen = 0;
    int  keys_seen = 0;
    int  settings_applied = 0;
    logic item_taken = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void launch(input logic [7:0] addr, input logic [7:0] data,
                                   input logic rd);
        addr_q = addr;
        data_q = data;
        reading = rd;
        bus_phase = PH_S1;
        transactions++;
    endfunction

    function automatic result_t advance_bus(input bus_tick_t t);
        result_t r;
        logic [7:0] seg;
        r = '0;
        r.scl = 1'b1;
        r.sda_drive = 1'b1;
        r.busy_res = 1'b1;
        if (bus_phase == PH_IDLE) begin
            case (t.func)
                FUNC_DIGIT: begin
                    if (t.sel < DIGIT_COUNT) begin
                        seg = (t.val < GLYPH_COUNT) ? segment_rom[t.val[4:0]] : BLANK_CODE;
                        if (t.dp && !seg7_mode) seg = seg | DP_MASK;
                        launch(ADDR_DIGIT0 + {t.sel[6:0], 1'b0}, seg, 1'b0);
                    end
                end
                FUNC_RAW: launch(t.sel, t.val, 1'b0);
                FUNC_KEY: launch(ADDR_KEY_RD, 8'h00, 1'b1);
                FUNC_ON: launch(ADDR_CTRL_WR, {1'b0, brightness, 4'h0}
                                | (seg7_mode ? CTRL_SEVEN : 8'h00) | CTRL_ON, 1'b0);
                FUNC_OFF: launch(ADDR_CTRL_WR, CTRL_OFF, 1'b0);
                default: ;
            endcase
        end
        case (bus_phase)
            PH_IDLE: begin
                r.busy_res = 1'b0;
                sda_level = 1'b1;
            end
            PH_S1: begin
                sda_level = 1'b1;
                nacked = 1'b0;
                bus_phase = PH_S2;
            end
            PH_S2: begin
                sda_level = 1'b0;
                bus_phase = PH_S3;
            end
            PH_S3: begin
                r.scl = 1'b0;
                sda_level = 1'b0;
                shifter = addr_q;
                shift_count = '0;
                in_data = 1'b0;
                bus_phase = PH_WSET;
            end
            PH_WSET: begin
                r.scl = 1'b0;
                sda_level = shifter[7];
                bus_phase = PH_WHI;
            end
            PH_WHI: bus_phase = PH_WLO;
            PH_WLO: begin
                r.scl = 1'b0;
                shifter = shifter << 1;
                shift_count = shift_count + 4'd1;
                if (shift_count >= 4'd8) bus_phase = in_data ? PH_NHI : PH_AREL;
                else bus_phase = PH_WSET;
            end
            PH_AREL: begin
                r.scl = 1'b0;
                r.sda_drive = 1'b0;
                sda_level = 1'b1;
                retries = '0;
                bus_phase = PH_AWAIT;
            end
            PH_AWAIT: begin
                r.scl = 1'b0;
                r.sda_drive = 1'b0;
                if (!t.sda) begin
                    bus_phase = PH_ADRV;
                end else begin
                    retries = retries + 16'd1;
                    if (retries >= retry_limit) begin
                        nacked = 1'b1;
                        r.ack_timeout = 1'b1;
                        bus_phase = PH_ADRV;
                    end
                end
            end
            PH_ADRV: begin
                r.scl = 1'b0;
                bus_phase = PH_AHI;
            end
            PH_AHI: bus_phase = PH_ALO;
            PH_ALO: begin
                r.scl = 1'b0;
                shift_count = '0;
                if (nacked) begin
                    bus_phase = PH_S1;
                end else if (reading) begin
                    shifter = '0;
                    bus_phase = PH_RREL;
                end else begin
                    shifter = data_q;
                    in_data = 1'b1;
                    bus_phase = PH_WSET;
                end
            end
            PH_RREL: begin
                r.scl = 1'b0;
                r.sda_drive = 1'b0;
                bus_phase = PH_RHI;
            end
            PH_RHI: begin
                r.sda_drive = 1'b0;
                shifter = {shifter[6:0], t.sda};
                shift_count = shift_count + 4'd1;
                if (shift_count >= 4'd8) begin
                    key_q = shifter;
                    r.key_valid = 1'b1;
                end
                bus_phase = PH_RLO;
            end
            PH_RLO: begin
                r.scl = 1'b0;
                r.sda_drive = 1'b0;
                bus_phase = (shift_count >= 4'd8) ? PH_NHI : PH_RHI;
            end
            PH_NHI: bus_phase = PH_NLO;
            PH_NLO: begin
                r.scl = 1'b0;
                bus_phase = PH_P1;
            end
            PH_P1: begin
                r.scl = 1'b0;
                sda_level = 1'b0;
                bus_phase = PH_P2;
            end
            PH_P2: begin
                sda_level = 1'b0;
                bus_phase = PH_P3;
            end
            default: begin
                sda_level = 1'b1;
                bus_phase = PH_IDLE;
            end
        endcase
        r.sda_out = sda_level;
        r.key_data = key_q;
        return r;
    endfunction

    task automatic compare_field(input string what, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : pin_monitor
        result_t   want;
        bus_tick_t seen;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles.", cycle_count);
            $display("seven_segment_two_wire_driver verification failed");
            $finish;
        end else if (aresetn) begin
            cycle_count++;
            if (m_valid && m_ready) begin
                if (pin_states_due.size() == 0) begin
                    $display("%0t: pin state with none expected, expected nothing actual %0h",
                             $time, {m_scl, m_sda_out, m_sda_drive, m_busy_res,
                                     m_key_valid, m_key_data, m_ack_timeout});
                    mismatches++;
                end else begin
                    want = pin_states_due.pop_front();
                    compare_field("scl", want.scl, m_scl);
                    compare_field("sda_out", want.sda_out, m_sda_out);
                    compare_field("sda_drive", want.sda_drive, m_sda_drive);
                    compare_field("busy_res", want.busy_res, m_busy_res);
                    compare_field("key_valid", want.key_valid, m_key_valid);
                    compare_field("key_data", want.key_data, m_key_data);
                    compare_field("ack_timeout", want.ack_timeout, m_ack_timeout);
                    results_checked++;
                end
            end
            if (s_valid && s_ready) begin
                seen.func = s_func;
                seen.sel = s_digit_or_address;
                seen.val = s_value;
                seen.dp = s_decimal_point;
                seen.sda = s_sda_in;
                want = advance_bus(seen);
                if (want.ack_timeout) timeouts_seen++;
                if (want.key_valid) keys_seen++;
                pin_states_due.push_back(want);
                items_accepted++;
                item_taken = 1'b1;
            end
        end
    end

    always @(negedge aclk) begin : tick_driver
        bus_tick_t nxt;
        logic quiet;
        quiet = (cycle_count >= 1500) && (cycle_count < 3500);
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            if (!s_valid || item_taken) begin
                item_taken = 1'b0;
                if (tick_backlog.size() != 0 && (quiet || $urandom_range(99) >= 11)) begin
                    nxt = tick_backlog.pop_front();
                    s_valid <= 1'b1;
                    s_func <= nxt.func;
                    s_digit_or_address <= nxt.sel;
                    s_value <= nxt.val;
                    s_decimal_point <= nxt.dp;
                    s_sda_in <= nxt.sda;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= quiet || ($urandom_range(99) >= 11);
        end
    end

    task automatic queue_item(input logic [2:0] f, input logic [7:0] sel,
                              input logic [7:0] val, input logic dp, input logic sda);
        bus_tick_t t;
        t.func = f;
        t.sel = sel;
        t.val = val;
        t.dp = dp;
        t.sda = sda;
        tick_backlog.push_back(t);
        queued_total++;
    endtask

    task automatic queue_ticks(input int count, input int ones_pct, input int noise_pct);
        logic [2:0] f;
        repeat (count) begin
            f = ($urandom_range(99) < noise_pct) ? 3'($urandom_range(7)) : FUNC_TICK;
            queue_item(f, 8'($urandom), 8'($urandom), 1'($urandom),
                       $urandom_range(99) < ones_pct);
        end
    endtask

    // Waits for every item to be checked, then feeds acknowledging ticks until
    // the sequencer is back in idle, so that register writes never land mid-transfer.
    task automatic drain_to_idle();
        logic settled;
        settled = 1'b0;
        while (!settled) begin
            @(negedge aclk);
            if (items_accepted == queued_total && results_checked == items_accepted) begin
                if (bus_phase == PH_IDLE) settled = 1'b1;
                else queue_ticks(8, 0, 0);
            end
        end
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_register(input reg_index_t idx, input logic [15:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_BRIGHTNESS: brightness = data[2:0];
            REG_SEVEN_SEG: seg7_mode = data[0];
            default: retry_limit = data;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_setting(input logic [2:0] b, input logic m, input logic [15:0] lim);
        write_register(REG_BRIGHTNESS, {13'd0, b});
        write_register(REG_SEVEN_SEG, {15'd0, m});
        write_register(REG_RETRY, lim);
        settings_applied++;
    endtask

    task automatic run_directed(input logic [2:0] f, input logic [7:0] sel,
                                input logic [7:0] val, input logic dp, input int ones_pct);
        queue_item(f, sel, val, dp, 1'b0);
        queue_ticks(70, ones_pct, 0);
        drain_to_idle();
    endtask

    initial begin : stimulus
        int setting_no;
        int random_items;
        int start_count;
        int ones;
        logic [2:0] f;
        logic [7:0] sel;
        logic [7:0] val;
        logic [15:0] lim;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        run_directed(FUNC_ON, 8'h00, 8'h00, 1'b0, 50);
        run_directed(FUNC_OFF, 8'hff, 8'hff, 1'b1, 50);
        run_directed(FUNC_KEY, 8'h00, 8'h00, 1'b0, 50);
        run_directed(FUNC_RAW, 8'h00, 8'h00, 1'b0, 50);
        run_directed(FUNC_RAW, 8'hff, 8'hff, 1'b1, 50);
        run_directed(FUNC_DIGIT, 8'd0, 8'd0, 1'b1, 50);
        run_directed(FUNC_DIGIT, 8'd3, 8'd19, 1'b0, 50);
        run_directed(FUNC_DIGIT, 8'd2, 8'd20, 1'b1, 50);
        run_directed(FUNC_DIGIT, 8'd1, 8'hff, 1'b0, 50);
        run_directed(FUNC_DIGIT, 8'd4, 8'd5, 1'b1, 50);
        run_directed(FUNC_DIGIT, 8'hff, 8'd5, 1'b1, 50);
        run_directed(3'd6, 8'h12, 8'h34, 1'b0, 50);
        run_directed(3'd7, 8'h12, 8'h34, 1'b1, 50);
        queue_item(FUNC_RAW, 8'h5a, 8'ha5, 1'b0, 1'b0);
        queue_ticks(5, 50, 0);
        queue_item(FUNC_KEY, 8'h00, 8'h00, 1'b0, 1'b0);
        queue_ticks(60, 50, 0);
        drain_to_idle();

        apply_setting(3'd7, 1'b1, 16'd1);
        run_directed(FUNC_DIGIT, 8'd0, 8'd8, 1'b1, 90);
        run_directed(FUNC_ON, 8'h00, 8'h00, 1'b0, 50);
        run_directed(FUNC_KEY, 8'h00, 8'h00, 1'b0, 90);
        apply_setting(3'd0, 1'b0, 16'd0);
        run_directed(FUNC_ON, 8'h00, 8'h00, 1'b0, 50);
        run_directed(FUNC_RAW, 8'h3c, 8'hc3, 1'b0, 100);
        apply_setting(3'd3, 1'b0, 16'hffff);
        run_directed(FUNC_DIGIT, 8'd2, 8'd18, 1'b1, 50);

        // Random part: mostly complete transactions with random content and random
        // data-line levels, with stray codes and commands issued while busy mixed in.
        random_items = 0;
        setting_no = 0;
        while (random_items < 900) begin
            case (setting_no)
                0: apply_setting(3'd7, 1'b1, 16'd1);
                1: apply_setting(3'd0, 1'b0, 16'hffff);
                default: begin
                    lim = ($urandom_range(1) != 0) ? 16'($urandom_range(4)) : 16'($urandom);
                    apply_setting(3'($urandom_range(7)), 1'($urandom_range(1)), lim);
                end
            endcase
            setting_no++;
            start_count = queued_total;
            while (queued_total - start_count < 180) begin
                f = 3'($urandom_range(1, 5));
                sel = ($urandom_range(9) == 0 || f == FUNC_RAW) ? 8'($urandom)
                                                                : 8'($urandom_range(3));
                val = ($urandom_range(4) == 0 || f == FUNC_RAW) ? 8'($urandom)
                                                                : 8'($urandom_range(19));
                ones = ($urandom_range(3) == 0) ? 90 : 45;
                queue_item(f, sel, val, 1'($urandom), $urandom_range(99) < ones);
                queue_ticks(($urandom_range(7) == 0) ? $urandom_range(1, 30)
                                                     : $urandom_range(55, 100), ones, 4);
            end
            random_items += queued_total - start_count;
            drain_to_idle();
        end

        repeat (20) @(negedge aclk);
        $display("Checked %0d pin states over %0d bus transactions under %0d register settings.",
                 results_checked, transactions, settings_applied);
        $display("The run saw %0d acknowledge timeouts and %0d key bytes read.",
                 timeouts_seen, keys_seen);
        if (mismatches == 0 && pin_states_due.size() == 0) begin
            $display("seven_segment_two_wire_driver verification clean");
        end else begin
            $display("seven_segment_two_wire_driver verification failed");
        end
        $finish;
    end

endmodule

// File: seven_segment_two_wire_driver.f
hw/rtl/ssd2w_pkg.sv
hw/rtl/seven_segment_two_wire_driver.sv
hw/rtl/ssd2w_checker.sv
tb/testbench.sv
